### rtl/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

   // default number of entries
   localparam int unsigned CAPACITY_DEFAULT = 16;

   // cells per first-level read reduction group
   localparam int unsigned GROUP = 16;

   // field widths
   localparam int unsigned CMD_W = 3;
   localparam int unsigned POSITION_W = 8;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned LEN_W = 5;
   // internal position: one more bit so that a tail position of 256 fits
   localparam int unsigned POS_W = POSITION_W + 1;

   // packed channel widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_USER_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_HEAD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_TAIL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_INDEX = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             ins;    // open a slot at pos and load value
      logic             del;    // close the slot at pos
      logic [POS_W-1:0] pos;    // effective position (also the read position)
      logic [VAL_W-1:0] value;  // value to load on insert
   } cell_ctrl_type;

endpackage

### rtl/positional_list_store.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: cmd; tdata: position, item_value
// rsp      out  rsp_tvalid/rsp_tready  tuser: valid_res, overflow;
//                                      tdata: read_value, length
//
// An item goes from acceptance to its result in order: the cells shift
// and the first-level read groups register on the accepting edge, the
// second-level read reduction fills the result register in S_REDUCE, and
// the result is shown from S_OUT. A new item is taken once the result is
// taken, so the block holds one item at a time.
// Reset clears the entry count and control; the entry cells are not cleared.
// A stalled result holds its payload until rsp_tready.

module positional_list_store #(
   parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // slave side
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pls_pkg::CMD_W-1:0]         req_tuser,   // [2:0] cmd
   input  logic [pls_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] position, [39:8] item_value
   // master side
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pls_pkg::RSP_USER_W-1:0]    rsp_tuser,   // [0] valid_res, [1] overflow
   output logic [pls_pkg::RSP_DATA_W-1:0]    rsp_tdata    // [31:0] read_value, [36:32] length,
                                                          // [39:37] zero
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned NGRP  = (CAPACITY + pls_pkg::GROUP - 1) / pls_pkg::GROUP;
   localparam int unsigned NPAD  = NGRP * pls_pkg::GROUP;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_REDUCE = 3'b010,
      S_OUT    = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;

   // unpack the request
   logic [pls_pkg::CMD_W-1:0]      cmd;
   logic [pls_pkg::POSITION_W-1:0] position;
   logic [pls_pkg::VAL_W-1:0]      item_value;

   assign cmd        = req_tuser;
   assign position   = req_tdata[pls_pkg::POSITION_W-1:0];
   assign item_value = req_tdata[pls_pkg::POSITION_W +: pls_pkg::VAL_W];

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // decode the command against the current count
   logic [pls_pkg::POS_W-1:0] count_pos, req_pos, eff_pos;
   logic is_add, full, in_range, ins_ok, ovf, del_ok, get_ok;

   assign count_pos = pls_pkg::POS_W'(count_ff);
   assign req_pos   = pls_pkg::POS_W'(position);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      is_add  = 1'b0;
      eff_pos = req_pos;
      case (cmd)
         pls_pkg::CMD_ADD_HEAD: begin
            is_add  = 1'b1;
            eff_pos = '0;
         end
         pls_pkg::CMD_ADD_TAIL: begin
            is_add  = 1'b1;
            eff_pos = count_pos;
         end
         pls_pkg::CMD_ADD_INDEX: begin
            is_add  = 1'b1;
         end
         default: begin
            is_add  = 1'b0;
         end
      endcase
   end

   assign in_range = (eff_pos <= count_pos);
   assign ins_ok   = is_add && in_range && !full;
   assign ovf      = is_add && in_range && full;    // past-the-end insert is not an overflow
   assign del_ok   = (cmd == pls_pkg::CMD_DELETE) && (req_pos < count_pos);
   assign get_ok   = (cmd == pls_pkg::CMD_GET) && (req_pos < count_pos);

   // broadcast to the cells; shifts only on an accepted item
   pls_pkg::cell_ctrl_type ctrl;
   assign ctrl.ins   = accept && ins_ok;
   assign ctrl.del   = accept && del_ok;
   assign ctrl.pos   = eff_pos;
   assign ctrl.value = item_value;

   // row of cells, each handing its value to both neighbours
   logic [pls_pkg::VAL_W-1:0] cell_val [CAPACITY];
   logic [pls_pkg::VAL_W-1:0] hit      [NPAD];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [pls_pkg::VAL_W-1:0] lower_val, upper_val;
      if (i == 0) begin : g_bottom
         assign lower_val = '0;               // never taken: no cell sits below
      end else begin : g_mid_lo
         assign lower_val = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
         assign upper_val = cell_val[i];      // top cell holds on delete
      end else begin : g_mid_hi
         assign upper_val = cell_val[i+1];
      end
      pls_cell #(.INDEX(i)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .lower_val (lower_val),
         .upper_val (upper_val),
         .value_out (cell_val[i]),
         .hit_out   (hit[i])
      );
   end

   for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
      assign hit[i] = '0;
   end

   // first-level read reduction, registered on the accepting edge
   logic [pls_pkg::VAL_W-1:0] grp_or [NGRP];
   logic [pls_pkg::VAL_W-1:0] grp_ff [NGRP];
   logic [pls_pkg::VAL_W-1:0] rd_or;

   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      pls_or_tree #(.N(pls_pkg::GROUP)) u_grp (
         .din  (hit[g*pls_pkg::GROUP +: pls_pkg::GROUP]),
         .dout (grp_or[g])
      );
      always_ff @(posedge clock) begin
         if (accept) begin
            grp_ff[g] <= grp_or[g];
         end
      end
   end

   pls_or_tree #(.N(NGRP)) u_final (
      .din  (grp_ff),
      .dout (rd_or)
   );

   // per-item flags, held from acceptance to the result register
   logic get_ok_ff, ok_ff, ovf_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         get_ok_ff <= get_ok;
         ok_ff     <= get_ok || ins_ok || del_ok;
         ovf_ff    <= ovf;
      end
   end

   // result register
   logic [pls_pkg::VAL_W-1:0] rsp_value_ff;
   logic                      rsp_ok_ff, rsp_ovf_ff;
   logic [pls_pkg::LEN_W-1:0] rsp_len_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_REDUCE) begin
         rsp_value_ff <= get_ok_ff ? rd_or : '1;   // -1 when nothing was read
         rsp_ok_ff    <= ok_ff;
         rsp_ovf_ff   <= ovf_ff;
         rsp_len_ff   <= pls_pkg::LEN_W'(count_ff);  // count modulo 32
      end
   end

   // count and sequencing
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = {rsp_ovf_ff, rsp_ok_ff};
   assign rsp_tdata  = pls_pkg::RSP_DATA_W'({rsp_len_ff, rsp_value_ff});

   // the count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // an item cannot both take effect and overflow
   a_ok_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result flags both valid and overflow");

   // an accepted insert grows the count by exactly one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance the count");

   // no new item while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

endmodule

### rtl/pls_cell.sv
`timescale 1ns / 1ps

module pls_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                          clock,
   input  pls_pkg::cell_ctrl_type        ctrl,
   input  logic [pls_pkg::VAL_W-1:0]     lower_val,
   input  logic [pls_pkg::VAL_W-1:0]     upper_val,
   output logic [pls_pkg::VAL_W-1:0]     value_out,
   output logic [pls_pkg::VAL_W-1:0]     hit_out
);

   localparam logic [pls_pkg::POS_W-1:0] IDX = pls_pkg::POS_W'(INDEX);

   logic [pls_pkg::VAL_W-1:0] val_ff;
   logic [pls_pkg::VAL_W-1:0] val_in;

   // insert: cells above pos take from below, the cell at pos loads
   // delete: cells at or above pos take from above
   always_comb begin
      val_in = val_ff;
      if (ctrl.ins) begin
         if (IDX > ctrl.pos) begin
            val_in = lower_val;
         end else if (IDX == ctrl.pos) begin
            val_in = ctrl.value;
         end
      end else if (ctrl.del) begin
         if (IDX >= ctrl.pos) begin
            val_in = upper_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign value_out = val_ff;
   assign hit_out   = (IDX == ctrl.pos) ? val_ff : '0;

endmodule

### rtl/pls_or_tree.sv
`timescale 1ns / 1ps

module pls_or_tree #(
   parameter int unsigned N = 16
) (
   input  logic [pls_pkg::VAL_W-1:0] din [N],
   output logic [pls_pkg::VAL_W-1:0] dout
);

   // at most one input is non-zero, so an OR acts as the select
   always_comb begin
      dout = '0;
      for (int i = 0; i < N; i++) begin
         dout = dout | din[i];
      end
   end

endmodule

### bench/pls_result_checker.sv
`timescale 1ns / 1ps

module pls_result_checker #(
   parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [pls_pkg::CMD_W-1:0]         req_tuser,
   input  logic [pls_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [pls_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic [pls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output int                                fail_count,
   output int                                pending,
   output int                                model_length,
   output int                                checked_count,
   output int                                overflow_count
);

   typedef struct packed {
      logic [pls_pkg::VAL_W-1:0] read_value;
      logic                      valid_res;
      logic                      overflow;
      logic [pls_pkg::LEN_W-1:0] length;
   } list_result_type;

   logic [pls_pkg::VAL_W-1:0] list_entries [CAPACITY];
   int unsigned               list_count;
   list_result_type           expected_results [$];

   // apply one command to the shadow list and return the result it must give
   function automatic list_result_type apply_list_command(
      input logic [pls_pkg::CMD_W-1:0]      code,
      input logic [pls_pkg::POSITION_W-1:0] where,
      input logic [pls_pkg::VAL_W-1:0]      value
   );
      list_result_type res;
      int unsigned     slot;
      int unsigned     k;
      logic            full;
      res.read_value = '1;
      res.valid_res  = 1'b0;
      res.overflow   = 1'b0;
      full = (list_count >= CAPACITY);
      slot = 32'(where);
      case (code)
         pls_pkg::CMD_GET: begin
            if (slot < list_count) begin
               res.read_value = list_entries[slot];
               res.valid_res  = 1'b1;
            end
         end
         pls_pkg::CMD_ADD_HEAD, pls_pkg::CMD_ADD_TAIL, pls_pkg::CMD_ADD_INDEX: begin
            if (code == pls_pkg::CMD_ADD_HEAD)
               slot = 0;
            else if (code == pls_pkg::CMD_ADD_TAIL)
               slot = list_count;
            if (slot <= list_count) begin
               if (full) begin
                  res.overflow = 1'b1;
               end else begin
                  for (k = list_count; k > slot; k--)
                     list_entries[k] = list_entries[k-1];
                  list_entries[slot] = value;
                  list_count++;
                  res.valid_res = 1'b1;
               end
            end
         end
         pls_pkg::CMD_DELETE: begin
            if (slot < list_count) begin
               for (k = slot; k + 1 < list_count; k++)
                  list_entries[k] = list_entries[k+1];
               list_count--;
               res.valid_res = 1'b1;
            end
         end
         default: ;
      endcase
      res.length = list_count[pls_pkg::LEN_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         expected_results.delete();
         list_count     = 0;
         fail_count     = 0;
         checked_count  = 0;
         overflow_count = 0;
      end else begin
         // push before pop: the queue stays in order either way
         if (req_tvalid && req_tready) begin
            want = apply_list_command(req_tuser, req_tdata[pls_pkg::POSITION_W-1:0],
                                      req_tdata[pls_pkg::POSITION_W +: pls_pkg::VAL_W]);
            if (want.overflow)
               overflow_count++;
            expected_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (expected_results.size() == 0) begin
               $error("result with no command outstanding: tuser %h tdata %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[pls_pkg::VAL_W-1:0] !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         $signed(want.read_value), $signed(rsp_tdata[pls_pkg::VAL_W-1:0]));
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.valid_res) begin
                  $error("valid_res: expected %0b, got %0b", want.valid_res, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[1] !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser[1]);
                  fail_count++;
               end
               if (rsp_tdata[pls_pkg::VAL_W +: pls_pkg::LEN_W] !== want.length) begin
                  $error("length: expected %0d, got %0d",
                         want.length, rsp_tdata[pls_pkg::VAL_W +: pls_pkg::LEN_W]);
                  fail_count++;
               end
               if (rsp_tdata[pls_pkg::RSP_DATA_W-1:pls_pkg::VAL_W+pls_pkg::LEN_W] !== '0) begin
                  $error("tdata padding: expected 0, got %b",
                         rsp_tdata[pls_pkg::RSP_DATA_W-1:pls_pkg::VAL_W+pls_pkg::LEN_W]);
                  fail_count++;
               end
            end
         end
      end
      pending      = expected_results.size();
      model_length = list_count;
   end

endmodule

### bench/positional_list_store_tb.sv
`timescale 1ns / 1ps

module positional_list_store_tb;

   localparam int unsigned CAPACITY = pls_pkg::CAPACITY_DEFAULT;

   // codes the block must treat as no-ops
   localparam logic [pls_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [pls_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   localparam int RANDOM_ITEMS = 950;
   localparam int IDLE_PCT     = 26;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_kind_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pls_pkg::CMD_W-1:0]        req_tuser  = '0;   // [2:0] cmd
   logic [pls_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;   // [7:0] position, [39:8] item_value
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pls_pkg::RSP_USER_W-1:0]   rsp_tuser;         // [0] valid_res, [1] overflow
   logic [pls_pkg::RSP_DATA_W-1:0]   rsp_tdata;         // [31:0] read_value, [36:32] length

   // set while both sides must run flat out
   logic steady = 1'b0;

   int fail_count;
   int pending;
   int model_length;
   int checked_count;
   int overflow_count;

   int gets_sent;
   int inserts_sent;
   int deletes_sent;
   int spares_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   positional_list_store #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   pls_result_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tuser      (rsp_tuser),
      .rsp_tdata      (rsp_tdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .model_length   (model_length),
      .checked_count  (checked_count),
      .overflow_count (overflow_count)
   );

   // Result back-pressure: drop ready about a quarter of the time, except
   // during the steady stretch where the sink takes every item.
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: end the run if neither channel moves an item for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Present one item from a falling edge and hold it until the block takes
   // it. Leave the task on the falling edge after acceptance, with valid
   // still high, so that the next call makes the only assignment there.
   task automatic send_item(
      input logic [pls_pkg::CMD_W-1:0]      code,
      input logic [pls_pkg::POSITION_W-1:0] where,
      input logic [pls_pkg::VAL_W-1:0]      value
   );
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tuser  <= pls_pkg::CMD_W'($urandom);
         req_tdata  <= pls_pkg::REQ_DATA_W'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {value, where};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      case (code)
         pls_pkg::CMD_GET:                        gets_sent++;
         pls_pkg::CMD_ADD_HEAD, pls_pkg::CMD_ADD_TAIL,
         pls_pkg::CMD_ADD_INDEX:                  inserts_sent++;
         pls_pkg::CMD_DELETE:                     deletes_sent++;
         default:                                 spares_sent++;
      endcase
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding result has been taken.
   task automatic drain_results;
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // Pick one command shaped by the current phase. Most positions land in
   // or just past the live range; a small share is noise over all codes
   // and the whole position field.
   task automatic send_random(input phase_kind_type phase);
      int                               roll;
      int                               len;
      int                               add_pct;
      int                               del_pct;
      logic [pls_pkg::CMD_W-1:0]        code;
      logic [pls_pkg::POSITION_W-1:0]   where;
      logic [pls_pkg::VAL_W-1:0]        value;
      len  = model_length;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW:   begin add_pct = 65; del_pct = 10; end
         PHASE_SHRINK: begin add_pct = 20; del_pct = 55; end
         default:      begin add_pct = 40; del_pct = 30; end
      endcase
      case ($urandom_range(0, 9))
         0:       value = 32'h8000_0000;
         1:       value = 32'h7FFF_FFFF;
         2:       value = '1;
         3:       value = '0;
         default: value = $urandom;
      endcase
      if (roll < add_pct) begin
         case ($urandom_range(0, 2))
            0:       code = pls_pkg::CMD_ADD_HEAD;
            1:       code = pls_pkg::CMD_ADD_TAIL;
            default: code = pls_pkg::CMD_ADD_INDEX;
         endcase
         // head and tail ignore the position, so let it roam freely
         where = pls_pkg::POSITION_W'((code == pls_pkg::CMD_ADD_INDEX) ?
                                      $urandom_range(0, len) : $urandom_range(0, 255));
      end else if (roll < add_pct + del_pct) begin
         code  = pls_pkg::CMD_DELETE;
         where = pls_pkg::POSITION_W'((len > 0) ? $urandom_range(0, len - 1) : 0);
      end else if (roll < add_pct + del_pct + 6) begin
         code  = pls_pkg::CMD_W'($urandom_range(0, 7));
         where = pls_pkg::POSITION_W'($urandom_range(0, 1) ? $urandom_range(0, 255) :
                                      len + $urandom_range(0, 2));
      end else begin
         code  = pls_pkg::CMD_GET;
         where = pls_pkg::POSITION_W'((len > 0) ? $urandom_range(0, len - 1) :
                                      $urandom_range(0, 2));
      end
      send_item(code, where, value);
   endtask

   initial begin : stimulus
      int                        sent;
      int                        phase_left;
      logic                      full_probed;
      phase_kind_type            phase;
      logic [pls_pkg::CMD_W-1:0] spare;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list: reads, delete and an insert past the end all miss.
      send_item(pls_pkg::CMD_GET,       8'd0,   32'd0);
      send_item(pls_pkg::CMD_GET,       8'd255, 32'd0);
      send_item(pls_pkg::CMD_DELETE,    8'd0,   32'd0);
      send_item(pls_pkg::CMD_ADD_INDEX, 8'd1,   32'hDEAD_BEEF);
      for (spare = CMD_SPARE_FIRST; spare != CMD_SPARE_LAST; spare++)
         send_item(spare, pls_pkg::POSITION_W'($urandom), $urandom);
      send_item(CMD_SPARE_LAST, 8'd255, 32'hFFFF_FFFF);

      // Build a short list: append via index equal to count, then both ends
      // with extreme values, then a middle insert.
      send_item(pls_pkg::CMD_ADD_INDEX, 8'd0,   32'h1234_5678);
      send_item(pls_pkg::CMD_ADD_HEAD,  8'd255, 32'h8000_0000);
      send_item(pls_pkg::CMD_ADD_TAIL,  8'd7,   32'h7FFF_FFFF);
      send_item(pls_pkg::CMD_ADD_INDEX, 8'd1,   32'h0000_0000);
      send_item(pls_pkg::CMD_GET,       8'd0,   32'd0);
      send_item(pls_pkg::CMD_GET,       8'd1,   32'd0);
      send_item(pls_pkg::CMD_GET,       8'd2,   32'd0);
      send_item(pls_pkg::CMD_GET,       8'd3,   32'd0);
      send_item(pls_pkg::CMD_GET,       8'd4,   32'd0);

      // Remove the last entry, miss past the end, then remove the head.
      send_item(pls_pkg::CMD_DELETE,    8'd3,   32'd0);
      send_item(pls_pkg::CMD_DELETE,    8'd3,   32'd0);
      send_item(pls_pkg::CMD_DELETE,    8'd0,   32'd0);
      send_item(pls_pkg::CMD_GET,       8'd255, 32'd0);
      send_item(pls_pkg::CMD_ADD_INDEX, 8'd2,   32'hFFFF_FFFF);
      drain_results();

      // Random phases of growth, shrinkage and mixed traffic. The first
      // phase grows so the full store is reached early.
      sent        = 0;
      phase       = PHASE_GROW;
      phase_left  = 60;
      full_probed = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         steady <= (sent >= 400 && sent < 560);
         if (sent == 700)
            drain_results();
         if (model_length == CAPACITY && !full_probed) begin
            // full store: every insert form overflows, a gap past the end does not
            send_item(pls_pkg::CMD_ADD_HEAD,  pls_pkg::POSITION_W'($urandom), $urandom);
            send_item(pls_pkg::CMD_ADD_TAIL,  pls_pkg::POSITION_W'($urandom), $urandom);
            send_item(pls_pkg::CMD_ADD_INDEX, pls_pkg::POSITION_W'(CAPACITY), $urandom);
            send_item(pls_pkg::CMD_ADD_INDEX, pls_pkg::POSITION_W'(CAPACITY + 1), $urandom);
            full_probed = 1'b1;
            sent += 4;
         end else begin
            send_random(phase);
            sent++;
         end
         phase_left--;
         if (phase_left <= 0) begin
            phase      = phase_kind_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 60);
         end
      end

      // Stop sending, let the last results drain, then keep the clock running
      // so that any stray result can still show up.
      steady     <= 1'b0;
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d gets, %0d inserts, %0d deletes, %0d spare codes.",
               gets_sent + inserts_sent + deletes_sent + spares_sent,
               gets_sent, inserts_sent, deletes_sent, spares_sent);
      $display("Compared %0d results, %0d of them inserts rejected on a full store.",
               checked_count, overflow_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
